// File: hdl/sorted_timer_queue_defines.svh
// assertion macros shared by the timer queue rtl
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clock, off during reset
`define STQ_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_timer_queue assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define STQ_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_timer_queue assertion failed");

`else

`define STQ_ASSERT_IMP(name, ante, cons)
`define STQ_ASSERT_NXT(name, ante, cons)

`endif

`endif

// File: hdl/stq_pkg.sv
package stq_pkg;

   // sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 32;
   localparam int USER_BITS   = 16;

   // remove with this kind matches any kind
   localparam logic [2:0] KIND_ANY = 3'd0;

   // request codes
   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_EXTRACT = 2'd2,
      OP_QUERY   = 2'd3
   } stq_op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_NOMATCH = 2'd2,
      ST_EMPTY   = 2'd3
   } stq_status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_EVAL  = 2'd1,
      S_APPLY = 2'd2
   } stq_state_type;

   // where a cell takes its next entry from
   typedef enum logic [1:0] {
      SRC_HOLD  = 2'd0,
      SRC_LEFT  = 2'd1,
      SRC_RIGHT = 2'd2,
      SRC_NEW   = 2'd3
   } stq_src_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] time_val;
      logic [7:0]           handler;
      logic [USER_BITS-1:0] user;
      logic [2:0]           kind;
   } stq_data_type;

   typedef struct packed {
      logic         valid;
      stq_data_type data;
   } stq_entry_type;

   // search key broadcast to every cell
   typedef struct packed {
      logic [TIME_BITS-1:0] time_val;
      logic [USER_BITS-1:0] user;
      logic [2:0]           kind;
   } stq_key_type;

   // per-cell command from the sequencer
   typedef struct packed {
      logic        eval;
      logic        commit;
      stq_src_type src;
   } stq_cell_cmd_type;

   // registered compare results of one cell
   typedef struct packed {
      logic open;
      logic match;
   } stq_flags_type;

   // inclusive prefix or from index 0 upward, log-depth
   function automatic logic [QUEUE_DEPTH-1:0] prefix_or(input logic [QUEUE_DEPTH-1:0] v);
      logic [QUEUE_DEPTH-1:0] acc;
      acc = v;
      for (int s = 1; s < QUEUE_DEPTH; s = s * 2) begin
         acc = acc | (acc << s);
      end
      return acc;
   endfunction

endpackage

// File: hdl/stq_cell.sv
module stq_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  stq_pkg::stq_cell_cmd_type cmd,
   input  stq_pkg::stq_key_type      key,
   input  stq_pkg::stq_entry_type    left_entry,
   input  stq_pkg::stq_entry_type    right_entry,
   input  stq_pkg::stq_entry_type    new_entry,
   output stq_pkg::stq_entry_type    entry,
   output stq_pkg::stq_flags_type    flags
);

   logic                  valid_ff;
   logic                  valid_in;
   stq_pkg::stq_data_type data_ff;
   stq_pkg::stq_data_type data_in;
   stq_pkg::stq_flags_type flags_ff;
   stq_pkg::stq_flags_type flags_in;
   stq_pkg::stq_entry_type sel_entry;

   assign entry = '{valid: valid_ff, data: data_ff};
   assign flags = flags_ff;

   // compare against the broadcast key
   always_comb begin
      flags_in.open  = !valid_ff || (data_ff.time_val >= key.time_val);
      flags_in.match = valid_ff && (data_ff.user == key.user) &&
                       ((key.kind == stq_pkg::KIND_ANY) || (data_ff.kind == key.kind));
   end

   // pick the next entry: hold, shift from a neighbor or take the new one
   always_comb begin
      case (cmd.src)
         stq_pkg::SRC_LEFT:  sel_entry = left_entry;
         stq_pkg::SRC_RIGHT: sel_entry = right_entry;
         stq_pkg::SRC_NEW:   sel_entry = new_entry;
         default:            sel_entry = entry;
      endcase
      if (cmd.commit) begin
         valid_in = sel_entry.valid;
         data_in  = sel_entry.data;
      end else begin
         valid_in = valid_ff;
         data_in  = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload and flags need no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (cmd.eval) begin
         flags_ff <= flags_in;
      end
   end

endmodule

// File: hdl/sorted_timer_queue.sv
// Sorted timer queue: a row of 16 cells holds timer entries in ascending order of
// expiry time, head in cell 0. Each request runs through an evaluate step and then an
// apply step: in the evaluate step every cell compares its entry against the request key
// (later-or-equal time for insert, user and kind match for remove), in the apply step
// all cells shift or load together and the result beat is registered. The next request
// is accepted in the apply step, in the same cycle as the previous one commits; an
// unread result holds the row in its apply step until rsp_ready. Insert lands before
// entries with an equal time; remove drops the first match in queue order, kind 0
// matching any kind.
`include "sorted_timer_queue_defines.svh"

module sorted_timer_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_timestamp,
   input  logic [7:0]  req_handler_id,
   input  logic [15:0] req_user_id,
   input  logic [2:0]  req_op_kind,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_at_head,
   output logic        rsp_left_empty,
   output logic [31:0] rsp_out_timestamp,
   output logic [7:0]  rsp_out_handler,
   output logic [15:0] rsp_out_user,
   output logic [2:0]  rsp_out_kind,
   output logic [31:0] rsp_remaining
);

   stq_pkg::stq_state_type state_ff, state_in;
   logic accept;
   logic commit;

   // request registers
   stq_pkg::stq_op_type           op_ff;
   stq_pkg::stq_key_type          key_ff;
   logic [7:0]                    handler_ff;
   logic [stq_pkg::TIME_BITS-1:0] now_ff;
   stq_pkg::stq_entry_type        new_entry;

   // cell row
   stq_pkg::stq_entry_type cell_entry [stq_pkg::QUEUE_DEPTH];
   stq_pkg::stq_flags_type cell_flags [stq_pkg::QUEUE_DEPTH];
   logic [stq_pkg::QUEUE_DEPTH-1:0] open_vec;
   logic [stq_pkg::QUEUE_DEPTH-1:0] match_vec;
   logic [stq_pkg::QUEUE_DEPTH-1:0] valid_vec;
   logic [stq_pkg::QUEUE_DEPTH-1:0] found_vec;
   logic full;
   stq_pkg::stq_entry_type head;
   logic [stq_pkg::TIME_BITS-1:0] diff;

   // result registers
   logic                    rsp_valid_ff, rsp_valid_in;
   stq_pkg::stq_status_type status_ff, status_in;
   logic                    at_head_ff, at_head_in;
   logic                    left_empty_ff, left_empty_in;
   logic [31:0]             out_time_ff, out_time_in;
   logic [7:0]              out_handler_ff, out_handler_in;
   logic [15:0]             out_user_ff, out_user_in;
   logic [2:0]              out_kind_ff, out_kind_in;
   logic [31:0]             remaining_ff, remaining_in;

   // handshake
   assign commit    = (state_ff == stq_pkg::S_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == stq_pkg::S_IDLE) || commit;
   assign accept    = req_valid && req_ready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stq_pkg::S_IDLE: begin
            if (accept) state_in = stq_pkg::S_EVAL;
         end
         stq_pkg::S_EVAL: begin
            state_in = stq_pkg::S_APPLY;
         end
         stq_pkg::S_APPLY: begin
            if (commit) state_in = accept ? stq_pkg::S_EVAL : stq_pkg::S_IDLE;
         end
         default: begin
            state_in = stq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture request beat
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff           <= stq_pkg::stq_op_type'(req_type);
         key_ff.time_val <= stq_pkg::TIME_BITS'(req_timestamp);
         key_ff.user     <= stq_pkg::USER_BITS'(req_user_id);
         key_ff.kind     <= req_op_kind;
         handler_ff      <= req_handler_id;
         now_ff          <= stq_pkg::TIME_BITS'(req_now);
      end
   end

   assign new_entry.valid         = 1'b1;
   assign new_entry.data.time_val = key_ff.time_val;
   assign new_entry.data.handler  = handler_ff;
   assign new_entry.data.user     = key_ff.user;
   assign new_entry.data.kind     = key_ff.kind;

   assign found_vec = stq_pkg::prefix_or(match_vec);
   assign full      = valid_vec[stq_pkg::QUEUE_DEPTH-1];
   assign head      = cell_entry[0];

   // cell row with per-cell source select
   for (genvar i = 0; i < stq_pkg::QUEUE_DEPTH; i++) begin : g_cell
      stq_pkg::stq_entry_type   left_entry;
      stq_pkg::stq_entry_type   right_entry;
      logic                     open_left;
      stq_pkg::stq_cell_cmd_type cmd;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign open_left  = 1'b0;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign open_left  = open_vec[i-1];
      end

      if (i == stq_pkg::QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      always_comb begin
         cmd.eval   = (state_ff == stq_pkg::S_EVAL);
         cmd.commit = commit;
         cmd.src    = stq_pkg::SRC_HOLD;
         case (op_ff)
            stq_pkg::OP_INSERT: begin
               if (!full) begin
                  if (open_left)             cmd.src = stq_pkg::SRC_LEFT;
                  else if (open_vec[i])      cmd.src = stq_pkg::SRC_NEW;
               end
            end
            stq_pkg::OP_REMOVE: begin
               if (found_vec[i]) cmd.src = stq_pkg::SRC_RIGHT;
            end
            stq_pkg::OP_EXTRACT: begin
               if (head.valid) cmd.src = stq_pkg::SRC_RIGHT;
            end
            default: begin
               cmd.src = stq_pkg::SRC_HOLD;
            end
         endcase
      end

      stq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .key         (key_ff),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .new_entry   (new_entry),
         .entry       (cell_entry[i]),
         .flags       (cell_flags[i])
      );

      assign open_vec[i]  = cell_flags[i].open;
      assign match_vec[i] = cell_flags[i].match;
      assign valid_vec[i] = cell_entry[i].valid;
   end

   assign diff = head.data.time_val - now_ff;

   // result beat
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      status_in      = status_ff;
      at_head_in     = at_head_ff;
      left_empty_in  = left_empty_ff;
      out_time_in    = out_time_ff;
      out_handler_in = out_handler_ff;
      out_user_in    = out_user_ff;
      out_kind_in    = out_kind_ff;
      remaining_in   = remaining_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (commit) begin
         rsp_valid_in   = 1'b1;
         status_in      = stq_pkg::ST_DONE;
         at_head_in     = 1'b0;
         left_empty_in  = 1'b0;
         out_time_in    = '0;
         out_handler_in = '0;
         out_user_in    = '0;
         out_kind_in    = '0;
         remaining_in   = '0;
         case (op_ff)
            stq_pkg::OP_INSERT: begin
               if (full) status_in = stq_pkg::ST_FULL;
               else      at_head_in = open_vec[0];
            end
            stq_pkg::OP_REMOVE: begin
               if (!found_vec[stq_pkg::QUEUE_DEPTH-1]) status_in = stq_pkg::ST_NOMATCH;
            end
            stq_pkg::OP_EXTRACT: begin
               if (!head.valid) begin
                  status_in     = stq_pkg::ST_EMPTY;
                  left_empty_in = 1'b1;
               end else begin
                  left_empty_in  = !valid_vec[1];
                  out_time_in    = 32'(head.data.time_val);
                  out_handler_in = head.data.handler;
                  out_user_in    = 16'(head.data.user);
                  out_kind_in    = head.data.kind;
               end
            end
            default: begin
               if (!head.valid) begin
                  status_in = stq_pkg::ST_EMPTY;
               end else if (head.data.time_val > now_ff) begin
                  if (64'(diff) > 64'h0000_0000_FFFF_FFFF) remaining_in = '1;
                  else                                      remaining_in = 32'(diff);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      at_head_ff     <= at_head_in;
      left_empty_ff  <= left_empty_in;
      out_time_ff    <= out_time_in;
      out_handler_ff <= out_handler_in;
      out_user_ff    <= out_user_in;
      out_kind_ff    <= out_kind_in;
      remaining_ff   <= remaining_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_at_head       = at_head_ff;
   assign rsp_left_empty    = left_empty_ff;
   assign rsp_out_timestamp = out_time_ff;
   assign rsp_out_handler   = out_handler_ff;
   assign rsp_out_user      = out_user_ff;
   assign rsp_out_kind      = out_kind_ff;
   assign rsp_remaining     = remaining_ff;

   // occupied cells always form a prefix of the row
   `STQ_ASSERT_IMP(a_valid_prefix, 1'b1, $onehot({1'b0, valid_vec} + {{stq_pkg::QUEUE_DEPTH{1'b0}}, 1'b1}))
   // a new result beat only comes out of the apply step
   `STQ_ASSERT_IMP(a_rsp_from_apply, $rose(rsp_valid_ff), $past(state_ff) == stq_pkg::S_APPLY)
   // insert into a queue with room adds exactly one entry
   `STQ_ASSERT_NXT(a_insert_grows, commit && (op_ff == stq_pkg::OP_INSERT) && !full, $countones(valid_vec) == $past($countones(valid_vec)) + 1)
   // extract from a non-empty queue leaves room at the tail
   `STQ_ASSERT_NXT(a_extract_frees, commit && (op_ff == stq_pkg::OP_EXTRACT) && head.valid, !valid_vec[stq_pkg::QUEUE_DEPTH-1])

endmodule
